/* rtl/vrrq_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the variable record ring queue.
package vrrq_pkg;

  localparam int unsigned DEF_QUEUE_BYTES       = 4096;
  localparam int unsigned DEF_MAX_CONTENT_BYTES = 2048;
  localparam int unsigned DEF_HEADER_BYTES      = 64;

  localparam int unsigned ALIGN_BYTES  = 8;
  localparam int unsigned ALIGN_SHIFT  = $clog2(ALIGN_BYTES);
  localparam int unsigned PREFIX_BYTES = 8;
  localparam int unsigned WORD_W       = 64;

  localparam logic [31:0] MAGIC_RECORD = 32'h4d53_4731;
  localparam logic [31:0] MAGIC_PAD    = 32'h5041_4431;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned POS_W    = 12;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned RLEN_W   = 12;
  localparam int unsigned USEDO_W  = 13;
  localparam int unsigned CNTO_W   = 10;
  localparam int unsigned DIR_W    = 2;
  localparam int unsigned RECLEN_W = LEN_W + 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_RELEASE = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_BIG     = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_CORRUPT = 3'd4,
    ST_IGNORED = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH_CHK,
    S_PUSH_HDR0,
    S_PUSH_HDR1,
    S_REL_POST,
    S_SKIP,
    S_SKIP_RD,
    S_POP_RD1,
    S_RESP
  } state_e;

  typedef struct packed {
    status_e             status;
    logic [POS_W-1:0]    record_pos;
    logic [POS_W-1:0]    content_pos;
    logic [RLEN_W-1:0]   record_content_len;
    logic [USEDO_W-1:0]  used_bytes;
    logic [CNTO_W-1:0]   message_count;
  } res_t;

endpackage

/* rtl/vrrq_if.sv */
`timescale 1ns / 1ps
// Request and response channel interfaces of the variable record ring queue.
interface vrrq_req_if;
  logic                         valid;
  logic                         ready;
  logic [vrrq_pkg::OP_W-1:0]    operation;
  logic [vrrq_pkg::LEN_W-1:0]   body_len;
  logic [vrrq_pkg::POS_W-1:0]   release_pos;

  modport source (output valid, output operation, output body_len, output release_pos,
                  input ready);
  modport sink (input valid, input operation, input body_len, input release_pos,
                output ready);
endinterface

interface vrrq_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [vrrq_pkg::STATUS_W-1:0] status;
  logic [vrrq_pkg::POS_W-1:0]    record_pos;
  logic [vrrq_pkg::POS_W-1:0]    content_pos;
  logic [vrrq_pkg::RLEN_W-1:0]   record_content_len;
  logic [vrrq_pkg::USEDO_W-1:0]  used_bytes;
  logic [vrrq_pkg::CNTO_W-1:0]   message_count;

  modport source (output valid, output status, output record_pos, output content_pos,
                  output record_content_len, output used_bytes, output message_count,
                  input ready);
  modport sink (input valid, input status, input record_pos, input content_pos,
                input record_content_len, input used_bytes, input message_count,
                output ready);
endinterface

/* rtl/vrrq_seq.sv */
`timescale 1ns / 1ps
// Sequencer of the ring queue: offsets, counts, lease and ring memory accesses.
module vrrq_seq #(
  parameter int unsigned QUEUE_BYTES       = vrrq_pkg::DEF_QUEUE_BYTES,
  parameter int unsigned MAX_CONTENT_BYTES = vrrq_pkg::DEF_MAX_CONTENT_BYTES,
  parameter int unsigned HEADER_BYTES      = vrrq_pkg::DEF_HEADER_BYTES,
  localparam int unsigned OFF_W  = $clog2(QUEUE_BYTES),
  localparam int unsigned IDX_W  = OFF_W - vrrq_pkg::ALIGN_SHIFT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          dir_we_i,
  input  logic [vrrq_pkg::DIR_W-1:0]    dir_i,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  logic [vrrq_pkg::OP_W-1:0]     req_op_i,
  input  logic [vrrq_pkg::LEN_W-1:0]    req_len_i,
  input  logic [vrrq_pkg::POS_W-1:0]    req_pos_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output vrrq_pkg::res_t                res_o,
  output logic                          mem_we_o,
  output logic                          mem_re_o,
  output logic [IDX_W-1:0]              mem_addr_o,
  output logic [vrrq_pkg::WORD_W-1:0]   mem_wdata_o,
  input  logic [vrrq_pkg::WORD_W-1:0]   mem_rdata_i
);

  localparam int unsigned USED_W     = $clog2(QUEUE_BYTES + 1);
  localparam int unsigned CNT_W      = OFF_W;
  localparam int unsigned RL_W       = vrrq_pkg::RECLEN_W;
  localparam int unsigned RING_DEPTH = QUEUE_BYTES / vrrq_pkg::ALIGN_BYTES;

  vrrq_pkg::state_e                state_q, state_d;
  logic [vrrq_pkg::OP_W-1:0]       op_q, op_d;
  logic [vrrq_pkg::LEN_W-1:0]      clen_q, clen_d;
  logic [RL_W-1:0]                 reclen_q, reclen_d;
  logic [OFF_W-1:0]                rd_q, rd_d;
  logic [OFF_W-1:0]                wr_q, wr_d;
  logic [USED_W-1:0]               used_q, used_d;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic                            lease_q, lease_d;
  logic [USED_W-1:0]               lease_len_q, lease_len_d;
  logic [OFF_W-1:0]                lease_off_q, lease_off_d;
  logic [vrrq_pkg::DIR_W-1:0]      dir_q, dir_d;
  logic [USED_W-1:0]               tl_q, tl_d;
  logic                            tl_bad_q, tl_bad_d;
  vrrq_pkg::status_e               st_q, st_d;
  logic [vrrq_pkg::POS_W-1:0]      recp_q, recp_d;
  logic [vrrq_pkg::POS_W-1:0]      conp_q, conp_d;
  logic [vrrq_pkg::RLEN_W-1:0]     rlen_q, rlen_d;

  logic [IDX_W-1:0]  rd_idx, rd_idx_nxt, wr_idx, wr_idx_nxt;
  logic [USED_W-1:0] tail_rd;
  logic [RL_W-1:0]   push_tail, push_need, push_free;
  logic              push_big, rel_match, do_clear;
  logic [31:0]       rd_magic, rd_tl;
  logic [OFF_W-1:0]  pop_conp;

  function automatic logic [OFF_W-1:0] adv(input logic [OFF_W-1:0] pos,
                                           input logic [USED_W-1:0] len);
    logic [USED_W:0] s;
    s = (USED_W + 1)'(pos) + (USED_W + 1)'(len);
    if (s >= (USED_W + 1)'(QUEUE_BYTES)) begin
      s = s - (USED_W + 1)'(QUEUE_BYTES);
    end
    return s[OFF_W-1:0];
  endfunction

  function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
    return (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  assign rd_idx     = rd_q[OFF_W-1:vrrq_pkg::ALIGN_SHIFT];
  assign wr_idx     = wr_q[OFF_W-1:vrrq_pkg::ALIGN_SHIFT];
  assign rd_idx_nxt = idx_next(rd_idx);
  assign wr_idx_nxt = idx_next(wr_idx);
  assign tail_rd    = USED_W'(QUEUE_BYTES) - USED_W'(rd_q);
  assign rd_magic   = mem_rdata_i[31:0];
  assign rd_tl      = mem_rdata_i[63:32];
  assign pop_conp   = adv(rd_q, USED_W'(HEADER_BYTES));

  assign push_big  = (RL_W'(clen_q) > RL_W'(MAX_CONTENT_BYTES)) ||
                     (reclen_q > RL_W'(QUEUE_BYTES));
  assign push_tail = RL_W'(QUEUE_BYTES) - RL_W'(wr_q);
  assign push_need = (push_tail >= reclen_q) ? reclen_q : push_tail + reclen_q;
  assign push_free = (used_q <= USED_W'(QUEUE_BYTES)) ?
                     RL_W'(QUEUE_BYTES) - RL_W'(used_q) : '0;
  assign rel_match = ({{OFF_W{1'b0}}, req_pos_i} == {{vrrq_pkg::POS_W{1'b0}}, lease_off_q});

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    clen_d      = clen_q;
    reclen_d    = reclen_q;
    rd_d        = rd_q;
    wr_d        = wr_q;
    used_d      = used_q;
    cnt_d       = cnt_q;
    lease_d     = lease_q;
    lease_len_d = lease_len_q;
    lease_off_d = lease_off_q;
    dir_d       = dir_we_i ? dir_i : dir_q;
    tl_d        = tl_q;
    tl_bad_d    = tl_bad_q;
    st_d        = st_q;
    recp_d      = recp_q;
    conp_d      = conp_q;
    rlen_d      = rlen_q;
    do_clear    = 1'b0;
    req_ready_o = 1'b0;
    res_valid_o = 1'b0;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_addr_o  = rd_idx;
    mem_wdata_o = '0;

    case (state_q)
      vrrq_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          op_d     = req_op_i;
          clen_d   = req_len_i;
          reclen_d = (RL_W'(HEADER_BYTES) + RL_W'(req_len_i) + RL_W'(vrrq_pkg::ALIGN_BYTES)) &
                     ~RL_W'(vrrq_pkg::ALIGN_BYTES - 1);
          st_d     = vrrq_pkg::ST_IGNORED;
          recp_d   = '0;
          conp_d   = '0;
          rlen_d   = '0;
          state_d  = vrrq_pkg::S_RESP;
          case (req_op_i)
            vrrq_pkg::OP_PUSH: begin
              state_d = vrrq_pkg::S_PUSH_CHK;
            end
            vrrq_pkg::OP_POP: begin
              if (cnt_q == '0 || lease_q) begin
                st_d = vrrq_pkg::ST_EMPTY;
              end else begin
                state_d = vrrq_pkg::S_SKIP;
              end
            end
            vrrq_pkg::OP_RELEASE: begin
              if (lease_q && rel_match) begin
                st_d        = vrrq_pkg::ST_OK;
                recp_d      = vrrq_pkg::POS_W'(rd_q);
                conp_d      = vrrq_pkg::POS_W'(lease_off_q);
                rd_d        = adv(rd_q, lease_len_q);
                used_d      = (lease_len_q <= used_q) ? used_q - lease_len_q : '0;
                cnt_d       = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
                lease_d     = 1'b0;
                lease_len_d = '0;
                lease_off_d = '0;
                state_d     = vrrq_pkg::S_REL_POST;
              end
            end
            default: begin
              st_d = vrrq_pkg::ST_IGNORED;
            end
          endcase
        end
      end

      vrrq_pkg::S_PUSH_CHK: begin
        state_d = vrrq_pkg::S_RESP;
        if (push_big) begin
          st_d = vrrq_pkg::ST_BIG;
        end else if (push_need > push_free) begin
          st_d = vrrq_pkg::ST_FULL;
        end else begin
          state_d = vrrq_pkg::S_PUSH_HDR0;
          if (push_tail < reclen_q) begin
            if (push_tail >= RL_W'(vrrq_pkg::PREFIX_BYTES)) begin
              mem_we_o    = 1'b1;
              mem_addr_o  = wr_idx;
              mem_wdata_o = {32'(push_tail), vrrq_pkg::MAGIC_PAD};
            end
            wr_d   = '0;
            used_d = used_q + USED_W'(push_tail);
          end
        end
      end

      vrrq_pkg::S_PUSH_HDR0: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = wr_idx;
        mem_wdata_o = {32'(reclen_q), vrrq_pkg::MAGIC_RECORD};
        state_d     = vrrq_pkg::S_PUSH_HDR1;
      end

      vrrq_pkg::S_PUSH_HDR1: begin
        mem_we_o    = 1'b1;
        mem_addr_o  = wr_idx_nxt;
        mem_wdata_o = {32'(dir_q), 32'(clen_q)};
        st_d        = vrrq_pkg::ST_OK;
        recp_d      = vrrq_pkg::POS_W'(wr_q);
        conp_d      = vrrq_pkg::POS_W'(adv(wr_q, USED_W'(HEADER_BYTES)));
        rlen_d      = vrrq_pkg::RLEN_W'(clen_q);
        wr_d        = adv(wr_q, USED_W'(reclen_q));
        used_d      = used_q + USED_W'(reclen_q);
        cnt_d       = cnt_q + 1'b1;
        state_d     = vrrq_pkg::S_RESP;
      end

      vrrq_pkg::S_REL_POST: begin
        if (used_q == '0) begin
          rd_d    = '0;
          wr_d    = '0;
          state_d = vrrq_pkg::S_RESP;
        end else begin
          state_d = vrrq_pkg::S_SKIP;
        end
      end

      vrrq_pkg::S_SKIP: begin
        if (used_q == '0) begin
          state_d = vrrq_pkg::S_RESP;
          if (op_q == vrrq_pkg::OP_POP) begin
            do_clear = 1'b1;
          end
        end else if (tail_rd < USED_W'(vrrq_pkg::PREFIX_BYTES)) begin
          rd_d   = '0;
          used_d = (tail_rd <= used_q) ? used_q - tail_rd : '0;
        end else begin
          mem_re_o   = 1'b1;
          mem_addr_o = rd_idx;
          state_d    = vrrq_pkg::S_SKIP_RD;
        end
      end

      vrrq_pkg::S_SKIP_RD: begin
        if (rd_magic == vrrq_pkg::MAGIC_RECORD) begin
          if (op_q == vrrq_pkg::OP_POP) begin
            tl_bad_d   = (rd_tl == '0) || (rd_tl > 32'(used_q));
            tl_d       = USED_W'(rd_tl);
            mem_re_o   = 1'b1;
            mem_addr_o = rd_idx_nxt;
            state_d    = vrrq_pkg::S_POP_RD1;
          end else begin
            state_d = vrrq_pkg::S_RESP;
          end
        end else if (rd_magic == vrrq_pkg::MAGIC_PAD && rd_tl != '0 &&
                     rd_tl <= 32'(tail_rd) && rd_tl <= 32'(used_q)) begin
          rd_d    = adv(rd_q, USED_W'(rd_tl));
          used_d  = used_q - USED_W'(rd_tl);
          state_d = vrrq_pkg::S_SKIP;
        end else begin
          do_clear = 1'b1;
          state_d  = vrrq_pkg::S_RESP;
        end
      end

      vrrq_pkg::S_POP_RD1: begin
        state_d = vrrq_pkg::S_RESP;
        if (tl_bad_q || rd_magic > 32'(MAX_CONTENT_BYTES)) begin
          do_clear = 1'b1;
        end else begin
          st_d        = vrrq_pkg::ST_OK;
          recp_d      = vrrq_pkg::POS_W'(rd_q);
          conp_d      = vrrq_pkg::POS_W'(pop_conp);
          rlen_d      = vrrq_pkg::RLEN_W'(rd_magic);
          lease_d     = 1'b1;
          lease_len_d = tl_q;
          lease_off_d = pop_conp;
        end
      end

      vrrq_pkg::S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = vrrq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = vrrq_pkg::S_IDLE;
      end
    endcase

    if (do_clear) begin
      rd_d        = '0;
      wr_d        = '0;
      used_d      = '0;
      cnt_d       = '0;
      lease_d     = 1'b0;
      lease_len_d = '0;
      lease_off_d = '0;
      st_d        = vrrq_pkg::ST_CORRUPT;
      recp_d      = '0;
      conp_d      = '0;
      rlen_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vrrq_pkg::S_IDLE;
      rd_q        <= '0;
      wr_q        <= '0;
      used_q      <= '0;
      cnt_q       <= '0;
      lease_q     <= 1'b0;
      lease_len_q <= '0;
      lease_off_q <= '0;
      dir_q       <= vrrq_pkg::DIR_W'(1);
    end else begin
      state_q     <= state_d;
      rd_q        <= rd_d;
      wr_q        <= wr_d;
      used_q      <= used_d;
      cnt_q       <= cnt_d;
      lease_q     <= lease_d;
      lease_len_q <= lease_len_d;
      lease_off_q <= lease_off_d;
      dir_q       <= dir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    clen_q   <= clen_d;
    reclen_q <= reclen_d;
    tl_q     <= tl_d;
    tl_bad_q <= tl_bad_d;
    st_q     <= st_d;
    recp_q   <= recp_d;
    conp_q   <= conp_d;
    rlen_q   <= rlen_d;
  end

  assign res_o.status             = st_q;
  assign res_o.record_pos         = recp_q;
  assign res_o.content_pos        = conp_q;
  assign res_o.record_content_len = rlen_q;
  assign res_o.used_bytes         = vrrq_pkg::USEDO_W'(used_q);
  assign res_o.message_count      = vrrq_pkg::CNTO_W'(cnt_q);

endmodule

/* rtl/variable_record_ring_queue.sv */
`timescale 1ns / 1ps
// Top level of the variable record ring queue: ring memory, sequencer and result register.
//
// Channel   Direction  Handshake     Carries
// req_i     in         valid/ready   operation, body_len, release_pos
// rsp_o     out        valid/ready   status, positions, lengths, used bytes, count
// config    in         write enable  queue_direction
//
// One item is handled at a time. Errors detected at acceptance, and a rejected push after its
// check, go straight to the response. A push writes the padding prefix, when one is needed, and
// the two header words in turn through the single write port. A release that leaves the ring
// not empty skips padding up to the next record. A pop reads ring words in turn through the
// registered read port, skipping each padding prefix and short tail. There is no clearing pass
// after reset. A stalled result holds in the output register while the next item is accepted.
module variable_record_ring_queue #(
  parameter int unsigned QUEUE_BYTES       = vrrq_pkg::DEF_QUEUE_BYTES,
  parameter int unsigned MAX_CONTENT_BYTES = vrrq_pkg::DEF_MAX_CONTENT_BYTES,
  parameter int unsigned HEADER_BYTES      = vrrq_pkg::DEF_HEADER_BYTES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        queue_direction_we_i,
  input  logic [vrrq_pkg::DIR_W-1:0]  queue_direction_i,
  vrrq_req_if.sink                    req_i,
  vrrq_rsp_if.source                  rsp_o
);

  localparam int unsigned OFF_W      = $clog2(QUEUE_BYTES);
  localparam int unsigned IDX_W      = OFF_W - vrrq_pkg::ALIGN_SHIFT;
  localparam int unsigned RING_DEPTH = QUEUE_BYTES / vrrq_pkg::ALIGN_BYTES;

  logic                          mem_we, mem_re;
  logic [IDX_W-1:0]              mem_addr;
  logic [vrrq_pkg::WORD_W-1:0]   mem_wdata, mem_rdata_q;
  logic [vrrq_pkg::WORD_W-1:0]   ring_mem [RING_DEPTH];

  logic                          res_valid, out_free;
  vrrq_pkg::res_t                res;
  logic                          rsp_valid_q;
  vrrq_pkg::res_t                rsp_q;

  vrrq_seq #(
    .QUEUE_BYTES       (QUEUE_BYTES),
    .MAX_CONTENT_BYTES (MAX_CONTENT_BYTES),
    .HEADER_BYTES      (HEADER_BYTES)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dir_we_i    (queue_direction_we_i),
    .dir_i       (queue_direction_i),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_op_i    (req_i.operation),
    .req_len_i   (req_i.body_len),
    .req_pos_i   (req_i.release_pos),
    .res_valid_o (res_valid),
    .res_ready_i (out_free),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_re_o    (mem_re),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata_q)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= ring_mem[mem_addr];
    end
  end

  assign out_free = !rsp_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (out_free) begin
      rsp_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && out_free) begin
      rsp_q <= res;
    end
  end

  assign rsp_o.valid              = rsp_valid_q;
  assign rsp_o.status             = rsp_q.status;
  assign rsp_o.record_pos         = rsp_q.record_pos;
  assign rsp_o.content_pos        = rsp_q.content_pos;
  assign rsp_o.record_content_len = rsp_q.record_content_len;
  assign rsp_o.used_bytes         = rsp_q.used_bytes;
  assign rsp_o.message_count      = rsp_q.message_count;

endmodule

/* rtl/vrrq_checker.sv */
`timescale 1ns / 1ps
// Port checker of the variable record ring queue and its bind to the top level.
module vrrq_checker #(
  parameter int unsigned QUEUE_BYTES  = vrrq_pkg::DEF_QUEUE_BYTES,
  parameter int unsigned HEADER_BYTES = vrrq_pkg::DEF_HEADER_BYTES
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [vrrq_pkg::STATUS_W-1:0] rsp_status_i,
  input logic [vrrq_pkg::POS_W-1:0]    rsp_record_pos_i,
  input logic [vrrq_pkg::POS_W-1:0]    rsp_content_pos_i,
  input logic [vrrq_pkg::RLEN_W-1:0]   rsp_record_content_len_i,
  input logic [vrrq_pkg::USEDO_W-1:0]  rsp_used_bytes_i,
  input logic [vrrq_pkg::CNTO_W-1:0]   rsp_message_count_i
);

  logic [vrrq_pkg::POS_W:0] cpos_sum, cpos_exp;

  assign cpos_sum = (vrrq_pkg::POS_W + 1)'(rsp_record_pos_i) +
                    (vrrq_pkg::POS_W + 1)'(HEADER_BYTES);
  assign cpos_exp = (cpos_sum >= (vrrq_pkg::POS_W + 1)'(QUEUE_BYTES)) ?
                    cpos_sum - (vrrq_pkg::POS_W + 1)'(QUEUE_BYTES) : cpos_sum;

  // A stalled item keeps its whole payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i &&
      $stable({rsp_status_i, rsp_record_pos_i, rsp_content_pos_i, rsp_record_content_len_i,
               rsp_used_bytes_i, rsp_message_count_i}))
    else $error("response changed while stalled");

  // The block works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request accepted while busy");

  // Failed operations report no positions and no length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i != vrrq_pkg::ST_OK |->
      rsp_record_pos_i == '0 && rsp_content_pos_i == '0 && rsp_record_content_len_i == '0)
    else $error("failed operation reports a position");

  // On success, content starts one header after the record, around the ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_status_i == vrrq_pkg::ST_OK && (QUEUE_BYTES <= 4096) |->
      rsp_content_pos_i == cpos_exp[vrrq_pkg::POS_W-1:0])
    else $error("content offset does not follow record offset");

endmodule

bind variable_record_ring_queue vrrq_checker #(
  .QUEUE_BYTES  (QUEUE_BYTES),
  .HEADER_BYTES (HEADER_BYTES)
) u_vrrq_checker (
  .clk_i                    (clk_i),
  .rst_ni                   (rst_ni),
  .req_valid_i              (req_i.valid),
  .req_ready_i              (req_i.ready),
  .rsp_valid_i              (rsp_o.valid),
  .rsp_ready_i              (rsp_o.ready),
  .rsp_status_i             (rsp_o.status),
  .rsp_record_pos_i         (rsp_o.record_pos),
  .rsp_content_pos_i        (rsp_o.content_pos),
  .rsp_record_content_len_i (rsp_o.record_content_len),
  .rsp_used_bytes_i         (rsp_o.used_bytes),
  .rsp_message_count_i      (rsp_o.message_count)
);
